// ----- rtl/hgu_pkg.sv -----
// Shared types and constants for the haptic gain upsampler.
// Used by hgu_scale, hgu_interp and haptic_gain_upsampler_x16; no dependencies.
package hgu_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 16;
  localparam int UPSAMPLE_DEF = 16;
  // Interpolation weights reach the largest upsample factor (16).
  localparam int WEIGHT_W     = 5;
  // Interpolation sums and their magnitudes, sized for the largest factor.
  localparam int ACC_W        = 22;
  localparam int MAG_W        = 21;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd45056;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t ch1;
    sample_t ch2;
    sample_t ch3;
  } frame_t;

  // One scaled frame handed from the gain stage to the interpolator.
  typedef struct packed {
    frame_t frame;
    logic   eob;
  } scaled_t;

endpackage

// ----- rtl/haptic_gain_upsampler_x16.sv -----
// Top level of the haptic gain upsampler: gain register, gain stage, upsampler.
// Depends on hgu_pkg, hgu_scale and hgu_interp.
//
//  channel   ports                                         direction
//  input     in_valid/in_ready, left, right, end_of_buffer  in
//  result    out_valid/out_ready, ch1..ch3, run_last, buf   out
//  config    cfg_valid/cfg_ready, cfg_data (gain, Q2.14)    in
//
// Each frame yields UPSAMPLE words (none for the first frame of a buffer,
// 2*UPSAMPLE for an end-of-buffer frame after a held one), one word a cycle,
// while the result channel is not stalled, set by the single sequencer.
// Frames pass the gain stage, sequencer, sum, product and output registers.
// Synchronous active-low reset; gain resets to unity, no clearing pass.
// A stalled result channel holds the whole pipeline; four frames queue ahead.
module haptic_gain_upsampler_x16 #(
  parameter int UPSAMPLE = hgu_pkg::UPSAMPLE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_left_sample,
  input  logic signed [15:0]          in_right_sample,
  input  logic                        in_end_of_buffer,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_sample_ch1,
  output logic signed [15:0]          out_sample_ch2,
  output logic signed [15:0]          out_sample_ch3,
  output logic                        out_run_last,
  output logic                        out_buffer_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hgu_pkg::GAIN_W-1:0]  cfg_data
);

  logic [hgu_pkg::GAIN_W-1:0] gain_r;
  logic                       frm_valid;
  logic                       frm_ready;
  hgu_pkg::scaled_t           frm_word;
  hgu_pkg::frame_t            out_frame;

  // Gain register, clamped to 2.75 on write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= hgu_pkg::GAIN_UNITY;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= (cfg_data > hgu_pkg::GAIN_MAX) ? hgu_pkg::GAIN_MAX : cfg_data;
    end
  end

  hgu_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_left   (in_left_sample),
    .in_right  (in_right_sample),
    .in_eob    (in_end_of_buffer),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_word  (frm_word)
  );

  hgu_interp #(
    .UPSAMPLE (UPSAMPLE)
  ) u_interp (
    .clk             (clk),
    .rst_n           (rst_n),
    .frm_valid       (frm_valid),
    .frm_ready       (frm_ready),
    .frm_word        (frm_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame       (out_frame),
    .out_run_last    (out_run_last),
    .out_buffer_last (out_buffer_last)
  );

  assign out_sample_ch1 = out_frame.ch1;
  assign out_sample_ch2 = out_frame.ch2;
  assign out_sample_ch3 = out_frame.ch3;

endmodule

// ----- rtl/hgu_scale.sv -----
// Gain stage: multiplies each channel by gain and a channel factor in Q2.14
// unless gain is unity. Needs hgu_pkg; feeds hgu_interp one frame per word.
module hgu_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hgu_pkg::GAIN_W-1:0]    gain,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hgu_pkg::sample_t              in_left,
  input  hgu_pkg::sample_t              in_right,
  input  logic                          in_eob,
  output logic                          frm_valid,
  input  logic                          frm_ready,
  output hgu_pkg::scaled_t              frm_word
);

  localparam int P1_W   = 33;
  localparam int PROD_W = 50;
  localparam int SHIFT  = 28;
  localparam int Q_W    = PROD_W - SHIFT;

  localparam logic signed [16:0] FACTOR_CH1 = 17'sd22118;
  localparam logic signed [16:0] FACTOR_CH2 = 17'sd27034;
  localparam logic signed [16:0] FACTOR_CH3 = 17'sd25395;

  localparam hgu_pkg::sample_t SAMPLE_MAX = 16'sh7fff;
  localparam hgu_pkg::sample_t SAMPLE_MIN = 16'sh8000;

  // Drop 28 fraction bits toward zero and saturate to 16 bits.
  function automatic hgu_pkg::sample_t sat_q28(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] m;
    logic [Q_W-1:0]    q;
    hgu_pkg::sample_t  res;
    m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    q = m[PROD_W-1:SHIFT];
    if (p[PROD_W-1]) begin
      res = (q > Q_W'(32768)) ? SAMPLE_MIN : hgu_pkg::sample_t'(~q[15:0] + 16'd1);
    end else begin
      res = (q > Q_W'(32767)) ? SAMPLE_MAX : hgu_pkg::sample_t'(q[15:0]);
    end
    return res;
  endfunction

  logic                             adv;
  logic                             v1_r, v2_r, v3_r, pend_v_r;
  hgu_pkg::sample_t                 l1_r, r1_r, l2_r, r2_r, l3_r, r3_r;
  logic                             e1_r, e2_r, e3_r;
  logic signed [P1_W-1:0]           pl2_r, pr2_r;
  logic signed [PROD_W-1:0]         pa3_r, pb3_r, pc3_r;
  logic signed [hgu_pkg::GAIN_W:0]  gain_s;
  hgu_pkg::scaled_t                 word_r, word_nxt;

  // The whole stage moves forward whenever its last register can be emptied.
  assign adv      = !pend_v_r || frm_ready;
  assign in_ready = adv;
  assign gain_s   = $signed({1'b0, gain});

  // Bypass on unity gain, otherwise saturate the scaled products.
  always_comb begin
    word_nxt.eob = e3_r;
    if (gain == hgu_pkg::GAIN_UNITY) begin
      word_nxt.frame.ch1 = l3_r;
      word_nxt.frame.ch2 = l3_r;
      word_nxt.frame.ch3 = r3_r;
    end else begin
      word_nxt.frame.ch1 = sat_q28(pa3_r);
      word_nxt.frame.ch2 = sat_q28(pb3_r);
      word_nxt.frame.ch3 = sat_q28(pc3_r);
    end
  end

  // Valid bits of the four registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else if (adv) begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      pend_v_r <= v3_r;
    end
  end

  // Payload: input register, gain products, factor products, scaled frame.
  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r   <= in_left;
      r1_r   <= in_right;
      e1_r   <= in_eob;
      pl2_r  <= l1_r * gain_s;
      pr2_r  <= r1_r * gain_s;
      l2_r   <= l1_r;
      r2_r   <= r1_r;
      e2_r   <= e1_r;
      pa3_r  <= pl2_r * FACTOR_CH1;
      pb3_r  <= pl2_r * FACTOR_CH2;
      pc3_r  <= pr2_r * FACTOR_CH3;
      l3_r   <= l2_r;
      r3_r   <= r2_r;
      e3_r   <= e2_r;
      word_r <= word_nxt;
    end
  end

  assign frm_valid = pend_v_r;
  assign frm_word  = word_r;

endmodule

// ----- rtl/hgu_interp.sv -----
// Interpolating upsampler: emits UPSAMPLE frames between held and new frame,
// and UPSAMPLE copies of the last frame of a buffer. Depends on hgu_pkg.
module hgu_interp #(
  parameter int UPSAMPLE = hgu_pkg::UPSAMPLE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frm_valid,
  output logic              frm_ready,
  input  hgu_pkg::scaled_t  frm_word,
  output logic              out_valid,
  input  logic              out_ready,
  output hgu_pkg::frame_t   out_frame,
  output logic              out_run_last,
  output logic              out_buffer_last
);

  localparam int PH_W  = (UPSAMPLE > 1) ? $clog2(UPSAMPLE) : 1;
  localparam int ACC_W = hgu_pkg::ACC_W;
  localparam int MAG_W = hgu_pkg::MAG_W;
  localparam int WT_W  = hgu_pkg::WEIGHT_W;
  localparam logic [PH_W-1:0]  LAST_PH = PH_W'(UPSAMPLE - 1);
  localparam logic [MAG_W-1:0] RECIP   = MAG_W'((1 << MAG_W) / UPSAMPLE);
  localparam logic [MAG_W-1:0] DIVISOR = MAG_W'(UPSAMPLE);

  typedef enum logic {GEN_INTERP, GEN_COPY} gen_mode_t;

  // Sequencer state.
  logic            busy_r, busy_nxt;
  gen_mode_t       mode_r, mode_nxt;
  logic [PH_W-1:0] phase_r, phase_nxt;
  hgu_pkg::frame_t cur_r, cur_nxt, held_r, held_nxt;
  logic            held_v_r, held_v_nxt;
  logic            eob_r, eob_nxt;

  logic            gen_en;
  logic            can_take;
  logic            take;
  logic            is_last;

  // Divide pipeline.
  logic                     g1_v_r, g2_v_r, out_v_r;
  logic signed [ACC_W-1:0]  acc_r [3];
  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic                     rl1_r, bl1_r, rl2_r, bl2_r;
  logic [MAG_W-1:0]         mag_r [3];
  logic [MAG_W-1:0]         mag_nxt [3];
  logic [2*MAG_W-1:0]       prod_r [3];
  logic                     neg_r [3];
  hgu_pkg::sample_t         res_nxt [3];
  hgu_pkg::sample_t         s0 [3];
  hgu_pkg::sample_t         s1 [3];
  logic signed [WT_W:0]     wa, wb;
  hgu_pkg::frame_t          out_frame_r;
  logic                     out_rl_r, out_bl_r;

  assign gen_en  = !out_v_r || out_ready;
  assign is_last = (phase_r == LAST_PH);

  // Next sequencer state: finish the current item, then load the next one.
  always_comb begin
    busy_nxt   = busy_r;
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    eob_nxt    = eob_r;
    if (busy_r && gen_en) begin
      if (is_last) begin
        phase_nxt = '0;
        if (mode_r == GEN_INTERP && eob_r) begin
          mode_nxt = GEN_COPY;
        end else begin
          busy_nxt = 1'b0;
          if (mode_r == GEN_COPY) begin
            held_nxt   = '0;
            held_v_nxt = 1'b0;
          end else begin
            held_nxt   = cur_r;
            held_v_nxt = 1'b1;
          end
        end
      end else begin
        phase_nxt = PH_W'(phase_r + 1'b1);
      end
    end
    // A new word is taken once the current one is finished or none is running.
    can_take = !busy_nxt;
    take     = frm_valid && can_take;
    if (take) begin
      cur_nxt   = frm_word.frame;
      eob_nxt   = frm_word.eob;
      phase_nxt = '0;
      if (held_v_nxt) begin
        busy_nxt = 1'b1;
        mode_nxt = GEN_INTERP;
      end else if (frm_word.eob) begin
        busy_nxt = 1'b1;
        mode_nxt = GEN_COPY;
      end else begin
        // First frame of a buffer only becomes the held frame.
        held_nxt   = frm_word.frame;
        held_v_nxt = 1'b1;
      end
    end
  end

  assign frm_ready = can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      mode_r   <= GEN_INTERP;
      phase_r  <= '0;
      held_v_r <= 1'b0;
      eob_r    <= 1'b0;
      held_r   <= '0;
    end else begin
      busy_r   <= busy_nxt;
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      held_v_r <= held_v_nxt;
      eob_r    <= eob_nxt;
      held_r   <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Weighted sum per channel; a copy uses the new frame at both ends.
  always_comb begin
    wa = $signed({1'b0, WT_W'(WT_W'(UPSAMPLE) - WT_W'(phase_r))});
    wb = $signed({1'b0, WT_W'(phase_r)});
    s1[0] = cur_r.ch1;
    s1[1] = cur_r.ch2;
    s1[2] = cur_r.ch3;
    if (mode_r == GEN_COPY) begin
      s0[0] = cur_r.ch1;
      s0[1] = cur_r.ch2;
      s0[2] = cur_r.ch3;
    end else begin
      s0[0] = held_r.ch1;
      s0[1] = held_r.ch2;
      s0[2] = held_r.ch3;
    end
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = wa * s0[k] + wb * s1[k];
      mag_nxt[k] = acc_r[k][ACC_W-1] ? MAG_W'(-acc_r[k]) : MAG_W'(acc_r[k]);
    end
  end

  // Quotient by reciprocal, one correction step, sign restored toward zero.
  always_comb begin
    logic [MAG_W-1:0] q0;
    logic [MAG_W-1:0] q;
    logic [MAG_W-1:0] rem;
    for (int k = 0; k < 3; k++) begin
      q0  = prod_r[k][2*MAG_W-1:MAG_W];
      rem = mag_r[k] - MAG_W'(q0 * DIVISOR);
      q   = (rem >= DIVISOR) ? MAG_W'(q0 + 1'b1) : q0;
      res_nxt[k] = neg_r[k] ? hgu_pkg::sample_t'(~q[15:0] + 16'd1)
                            : hgu_pkg::sample_t'(q[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r  <= 1'b0;
      g2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (gen_en) begin
      g1_v_r  <= busy_r;
      g2_v_r  <= g1_v_r;
      out_v_r <= g2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_en) begin
      for (int k = 0; k < 3; k++) begin
        acc_r[k]  <= acc_nxt[k];
        mag_r[k]  <= mag_nxt[k];
        prod_r[k] <= mag_nxt[k] * RECIP;
        neg_r[k]  <= acc_r[k][ACC_W-1];
      end
      rl1_r           <= is_last && (mode_r == GEN_COPY || !eob_r);
      bl1_r           <= is_last && (mode_r == GEN_COPY);
      rl2_r           <= rl1_r;
      bl2_r           <= bl1_r;
      out_rl_r        <= rl2_r;
      out_bl_r        <= bl2_r;
      out_frame_r.ch1 <= res_nxt[0];
      out_frame_r.ch2 <= res_nxt[1];
      out_frame_r.ch3 <= res_nxt[2];
    end
  end

  assign out_valid       = out_v_r;
  assign out_frame       = out_frame_r;
  assign out_run_last    = out_rl_r;
  assign out_buffer_last = out_bl_r;

`ifndef ASSERT_OFF
  a_buffer_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_bl_r) |-> out_rl_r)
    else $error("buffer_last word without run_last");

  a_copy_only_on_eob: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && mode_r == GEN_COPY) |-> eob_r)
    else $error("copy phase for a frame that does not end a buffer");

  a_held_clear_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(held_v_r) |-> $past(mode_r == GEN_COPY && busy_r))
    else $error("held frame dropped outside the end of a buffer");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for haptic_gain_upsampler_x16: directed frames, then random buffers.
// A built-in predictor of gain, scaling and x16 interpolation checks every result word.
// Depends on hgu_pkg and the haptic_gain_upsampler_x16 RTL.
`timescale 1ns / 1ps

module tb;

  localparam int UPS = hgu_pkg::UPSAMPLE_DEF;
  localparam int SEG_ITEMS = 50;
  localparam int NUM_SEGS = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  // Q2.14 channel factors: 1.35, 1.65 and 1.55.
  localparam int CH_FACTOR [3] = '{22118, 27034, 25395};

  typedef logic [hgu_pkg::GAIN_W-1:0] gain_t;

  typedef struct packed {
    hgu_pkg::sample_t ch1;
    hgu_pkg::sample_t ch2;
    hgu_pkg::sample_t ch3;
    logic    run_last;
    logic    buffer_last;
  } out_word_t;

  typedef struct {
    int left;
    int right;
    bit eob;
    bit typed;
    int ch1;
    int ch2;
    int ch3;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hgu_pkg::sample_t in_left_sample = '0;
  hgu_pkg::sample_t in_right_sample = '0;
  logic in_end_of_buffer = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  hgu_pkg::sample_t out_sample_ch1;
  hgu_pkg::sample_t out_sample_ch2;
  hgu_pkg::sample_t out_sample_ch3;
  logic out_run_last;
  logic out_buffer_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  gain_t cfg_data = '0;

  // Predictor state: gain register and the held frame.
  gain_t gain_q14 = hgu_pkg::GAIN_UNITY;
  hgu_pkg::sample_t held_frame [3] = '{16'sd0, 16'sd0, 16'sd0};
  bit held_valid = 1'b0;

  out_word_t expected_words [$];
  out_word_t want;
  int mismatch_count = 0;
  int stall_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  // Directed frames at the reset gain. Typed rows are single-frame buffers whose
  // words are plain copies of the input; the others go through the predictor.
  stim_row_t directed_rows [0:13] = '{
    '{32767, -32768, 1'b1, 1'b1, 32767, 32767, -32768},
    '{-32768, 32767, 1'b1, 1'b1, -32768, -32768, 32767},
    '{0, 0, 1'b1, 1'b1, 0, 0, 0},
    '{-1, 1, 1'b1, 1'b1, -1, -1, 1},
    '{32767, -32768, 1'b0, 1'b0, 0, 0, 0},
    '{-32768, 32767, 1'b0, 1'b0, 0, 0, 0},
    '{32767, 32767, 1'b0, 1'b0, 0, 0, 0},
    '{-32768, -32768, 1'b1, 1'b0, 0, 0, 0},
    '{21845, -21846, 1'b0, 1'b0, 0, 0, 0},
    '{-21846, 21845, 1'b0, 1'b0, 0, 0, 0},
    '{1, -1, 1'b1, 1'b0, 0, 0, 0},
    '{-7, 9, 1'b0, 1'b0, 0, 0, 0},
    '{5, -3, 1'b0, 1'b0, 0, 0, 0},
    '{-32768, 32767, 1'b0, 1'b0, 0, 0, 0}
  };

  // Gains per random segment; the first one changes the gain mid-buffer.
  int unsigned segment_gains [NUM_SEGS] = '{45056, 0, 65535, 16383, 16385,
                                            16384, 30000, 8192, 100, 45055};

  haptic_gain_upsampler_x16 u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_end_of_buffer(in_end_of_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_ch1  (out_sample_ch1),
    .out_sample_ch2  (out_sample_ch2),
    .out_sample_ch3  (out_sample_ch3),
    .out_run_last    (out_run_last),
    .out_buffer_last (out_buffer_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample times gain times channel factor, truncated toward zero and saturated.
  function automatic hgu_pkg::sample_t scale_channel(hgu_pkg::sample_t s, gain_t g, int f);
    longint prod;
    longint mag;
    prod = longint'(s) * longint'({48'd0, g}) * longint'(f);
    mag = (prod < 0) ? -prod : prod;
    mag = mag >> 28;
    if (prod < 0) begin
      return (mag > 32768) ? -16'sd32768 : hgu_pkg::sample_t'(-mag);
    end
    return (mag > 32767) ? 16'sd32767 : hgu_pkg::sample_t'(mag);
  endfunction

  // Words caused by one accepted frame; updates the held frame.
  function automatic void predict_frame(input hgu_pkg::sample_t left,
                                        input hgu_pkg::sample_t right,
                                        input logic eob, output out_word_t words [$]);
    hgu_pkg::sample_t raw [3];
    hgu_pkg::sample_t cur [3];
    hgu_pkg::sample_t mix [3];
    int acc;
    out_word_t w;
    words = {};
    raw[0] = left;
    raw[1] = left;
    raw[2] = right;
    for (int j = 0; j < 3; j++) begin
      cur[j] = (gain_q14 == hgu_pkg::GAIN_UNITY) ? raw[j]
               : scale_channel(raw[j], gain_q14, CH_FACTOR[j]);
    end
    // Interpolate from the held frame toward the new one.
    if (held_valid) begin
      for (int p = 0; p < UPS; p++) begin
        for (int j = 0; j < 3; j++) begin
          acc = (UPS - p) * int'(held_frame[j]) + p * int'(cur[j]);
          mix[j] = hgu_pkg::sample_t'(acc / UPS);
        end
        w = '{mix[0], mix[1], mix[2], (!eob && p == UPS - 1), 1'b0};
        words.push_back(w);
      end
    end
    // End of buffer: hold the last frame for a full run of words.
    if (eob) begin
      for (int p = 0; p < UPS; p++) begin
        w = '{cur[0], cur[1], cur[2], (p == UPS - 1), (p == UPS - 1)};
        words.push_back(w);
      end
    end
    held_valid = !eob;
    for (int j = 0; j < 3; j++) begin
      held_frame[j] = eob ? hgu_pkg::sample_t'(0) : cur[j];
    end
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("tb: mismatch %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
    mismatch_count++;
  endtask

  task automatic compare_field(string what, int got, int exp_val);
    if (got != exp_val) begin
      report_mismatch(what, got, exp_val);
    end
  endtask

  // Drives one frame and records what it should produce once it is accepted.
  task automatic send_frame(hgu_pkg::sample_t left, hgu_pkg::sample_t right, logic eob,
                            bit typed, hgu_pkg::sample_t t1, hgu_pkg::sample_t t2,
                            hgu_pkg::sample_t t3);
    out_word_t words [$];
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_sample <= left;
    in_right_sample <= right;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
    predict_frame(left, right, eob, words);
    if (typed) begin
      words = {};
      for (int p = 0; p < UPS; p++) begin
        words.push_back('{t1, t2, t3, (p == UPS - 1), (p == UPS - 1)});
      end
    end
    foreach (words[k]) expected_words.push_back(words[k]);
  endtask

  task automatic write_gain(gain_t g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_q14 = (g > hgu_pkg::GAIN_MAX) ? hgu_pkg::GAIN_MAX : g;
  endtask

  // Waits for every expected word, then lets a frame with no words finish.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mix of extremes, small values and full-range values.
  function automatic hgu_pkg::sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return hgu_pkg::sample_t'(int'($urandom_range(0, 2)) - 1);
      3: return hgu_pkg::sample_t'(int'($urandom_range(0, 600)) - 300);
      default: return hgu_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Stimulus: reset, directed frames, then random buffers over several gains.
  initial begin
    int n;
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_frame(hgu_pkg::sample_t'(directed_rows[i].left),
                 hgu_pkg::sample_t'(directed_rows[i].right),
                 directed_rows[i].eob, directed_rows[i].typed,
                 hgu_pkg::sample_t'(directed_rows[i].ch1),
                 hgu_pkg::sample_t'(directed_rows[i].ch2),
                 hgu_pkg::sample_t'(directed_rows[i].ch3));
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      // Idle pattern: sender rarely and receiver often, then swapped, then none.
      if (seg < 4) begin
        sender_idle_pct = 6;
        receiver_idle_pct = 78;
      end else if (seg < 7) begin
        sender_idle_pct = 78;
        receiver_idle_pct = 6;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      wait_drained();
      write_gain(gain_t'(segment_gains[seg]));
      n = 0;
      while (n < SEG_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
        for (int k = 0; k < len && n < SEG_ITEMS; k++) begin
          send_frame(rand_sample(), rand_sample(), (k == len - 1), 1'b0, '0, '0, '0);
          n++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Result side: check each accepted word, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected, ch1", int'(out_sample_ch1), 0);
      end else begin
        want = expected_words.pop_front();
        compare_field("sample_ch1", int'(out_sample_ch1), int'(want.ch1));
        compare_field("sample_ch2", int'(out_sample_ch2), int'(want.ch2));
        compare_field("sample_ch3", int'(out_sample_ch3), int'(want.ch3));
        compare_field("run_last", int'(out_run_last), int'(want.run_last));
        compare_field("buffer_last", int'(out_buffer_last), int'(want.buffer_last));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
